/* rtl/mcr_pkg.sv */
// Shared constants, types and helpers for the midpoint circle rasterizer.
package mcr_pkg;

    localparam int COORD_BITS = 11;
    localparam int ROOT_BITS  = COORD_BITS + 1;
    localparam int RAD_BITS   = 2 * ROOT_BITS;
    localparam int REM_BITS   = ROOT_BITS + 1;
    localparam int DEC_BITS   = COORD_BITS + 5;
    localparam int CMP_BITS   = ROOT_BITS + 2;
    localparam int OUT_BITS   = 14;
    localparam int WIDE_BITS  = (ROOT_BITS > OUT_BITS) ? ROOT_BITS : OUT_BITS;
    localparam int CNT_BITS   = $clog2(ROOT_BITS);
    localparam int PT_BITS    = 3;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [PT_BITS-1:0] LAST_POINT = 3'd7;

    // Per-point octant mapping, bit k serves point k of a step.
    localparam logic [7:0] PT_SWAP  = 8'b1111_0000;
    localparam logic [7:0] PT_NEG_X = 8'b1100_1100;
    localparam logic [7:0] PT_NEG_Y = 8'b1001_1010;

    localparam logic [DEC_BITS-1:0] DEC_ONE     = DEC_BITS'(1);
    localparam logic [DEC_BITS-1:0] DEC_INC_NEG = DEC_BITS'(3);
    localparam logic [DEC_BITS-1:0] DEC_INC_POS = DEC_BITS'(5);

    typedef struct packed {
        logic               load_start;
        logic               sq_x;
        logic               sq_y;
        logic               root_step;
        logic               root_last;
        logic               step_take;
        logic               out_load;
        logic [PT_BITS-1:0] pt_idx;
    } mcr_cmd_t;

    typedef struct packed {
        logic active;
        logic out_free;
    } mcr_stat_t;

    function automatic logic [OUT_BITS-1:0] to_out(input logic [ROOT_BITS-1:0] v);
        logic [WIDE_BITS-1:0] w;
        w = WIDE_BITS'(v);
        return w[OUT_BITS-1:0];
    endfunction

endpackage

/* rtl/mcr_ctrl.sv */
// Sequencer for the midpoint circle rasterizer: start setup and point emission.
module mcr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_opcode,
    input  mcr_pkg::mcr_stat_t  stat,
    output mcr_pkg::mcr_cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_ROOT,
        ST_EMIT
    } state_t;

    state_t                           state_reg, state_next;
    logic [mcr_pkg::CNT_BITS-1:0]     cnt_reg, cnt_next;
    logic [mcr_pkg::PT_BITS-1:0]      idx_reg, idx_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.pt_idx = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_opcode == mcr_pkg::OP_START) begin
                        cmd.load_start = 1'b1;
                        state_next     = ST_SQX;
                    end else if (stat.active) begin
                        cmd.step_take = 1'b1;
                        idx_next      = '0;
                        state_next    = ST_EMIT;
                    end
                end
            end
            ST_SQX: begin
                cmd.sq_x   = 1'b1;
                state_next = ST_SQY;
            end
            ST_SQY: begin
                cmd.sq_y   = 1'b1;
                cnt_next   = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == mcr_pkg::CNT_BITS'(mcr_pkg::ROOT_BITS - 1)) begin
                    cmd.root_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    idx_next     = idx_reg + 1'b1;
                    if (idx_reg == mcr_pkg::LAST_POINT) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

/* rtl/mcr_datapath.sv */
// Datapath: radius square root, midpoint decision update and point output register.
module mcr_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  mcr_pkg::mcr_cmd_t                     cmd,
    output mcr_pkg::mcr_stat_t                    stat,
    input  logic [mcr_pkg::COORD_BITS-1:0]        s_center_x,
    input  logic [mcr_pkg::COORD_BITS-1:0]        s_center_y,
    input  logic [mcr_pkg::COORD_BITS-1:0]        s_edge_x,
    input  logic [mcr_pkg::COORD_BITS-1:0]        s_edge_y,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [mcr_pkg::OUT_BITS-1:0]   m_point_x,
    output logic signed [mcr_pkg::OUT_BITS-1:0]   m_point_y,
    output logic                                  m_last_of_step,
    output logic                                  m_circle_done
);

    localparam int CB = mcr_pkg::COORD_BITS;
    localparam int RB = mcr_pkg::ROOT_BITS;
    localparam int DB = mcr_pkg::DEC_BITS;
    localparam int OB = mcr_pkg::OUT_BITS;
    localparam int MB = mcr_pkg::CMP_BITS;

    logic [CB-1:0]                origin_x_reg, origin_y_reg;
    logic [CB-1:0]                dx_reg, dy_reg;
    logic [mcr_pkg::RAD_BITS-1:0] opnd_reg;
    logic [RB-1:0]                root_reg;
    logic [mcr_pkg::REM_BITS-1:0] rem_reg;
    logic [RB-1:0]                step_x_reg, step_y_reg;
    logic [DB-1:0]                decision_reg;
    logic                         active_reg;
    logic [RB-1:0]                snap_x_reg, snap_y_reg;
    logic                         snap_done_reg;
    logic                         m_valid_reg;
    logic signed [OB-1:0]         px_reg, py_reg;
    logic                         last_reg, done_reg;

    // shared squarer
    logic [CB-1:0]   mul_a;
    logic [2*CB-1:0] prod;
    assign mul_a = cmd.sq_x ? dx_reg : dy_reg;
    assign prod  = mul_a * mul_a;

    // one root digit per cycle
    logic [mcr_pkg::REM_BITS+1:0] rem_sh, trial;
    logic                         take;
    logic [RB-1:0]                root_next;
    assign rem_sh    = {rem_reg, opnd_reg[mcr_pkg::RAD_BITS-1 -: 2]};
    assign trial     = (mcr_pkg::REM_BITS + 2)'({root_reg, 2'b01});
    assign take      = (rem_sh >= trial);
    assign root_next = {root_reg[RB-2:0], take};

    // midpoint update
    logic          dec_neg;
    logic [DB-1:0] x_d, y_d, dec_next;
    logic [MB-1:0] x_c, y_c;
    assign dec_neg  = decision_reg[DB-1];
    assign x_d      = DB'(step_x_reg);
    assign y_d      = DB'(step_y_reg);
    assign dec_next = dec_neg ? decision_reg + (x_d << 1) + mcr_pkg::DEC_INC_NEG
                              : decision_reg + ((x_d - y_d) << 1) + mcr_pkg::DEC_INC_POS;
    assign x_c = MB'(step_x_reg) + MB'(1);
    assign y_c = MB'(step_y_reg) - MB'(!dec_neg);

    // point selection
    logic [RB-1:0] sel_a, sel_b;
    logic [OB-1:0] ox_o, oy_o, a_o, b_o, px_w, py_w;
    assign sel_a = mcr_pkg::PT_SWAP[cmd.pt_idx] ? snap_y_reg : snap_x_reg;
    assign sel_b = mcr_pkg::PT_SWAP[cmd.pt_idx] ? snap_x_reg : snap_y_reg;
    assign ox_o  = mcr_pkg::to_out(RB'(origin_x_reg));
    assign oy_o  = mcr_pkg::to_out(RB'(origin_y_reg));
    assign a_o   = mcr_pkg::to_out(sel_a);
    assign b_o   = mcr_pkg::to_out(sel_b);
    assign px_w  = mcr_pkg::PT_NEG_X[cmd.pt_idx] ? ox_o - a_o : ox_o + a_o;
    assign py_w  = mcr_pkg::PT_NEG_Y[cmd.pt_idx] ? oy_o - b_o : oy_o + b_o;

    assign stat.active   = active_reg;
    assign stat.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load_start) begin
            origin_x_reg <= s_center_x;
            origin_y_reg <= s_center_y;
            dx_reg <= (s_edge_x >= s_center_x) ? s_edge_x - s_center_x : s_center_x - s_edge_x;
            dy_reg <= (s_edge_y >= s_center_y) ? s_edge_y - s_center_y : s_center_y - s_edge_y;
        end
        if (cmd.sq_x) begin
            opnd_reg <= mcr_pkg::RAD_BITS'(prod);
        end
        if (cmd.sq_y) begin
            opnd_reg <= opnd_reg + mcr_pkg::RAD_BITS'(prod);
            root_reg <= '0;
            rem_reg  <= '0;
        end
        if (cmd.root_step) begin
            opnd_reg <= opnd_reg << 2;
            root_reg <= root_next;
            rem_reg  <= take ? mcr_pkg::REM_BITS'(rem_sh - trial)
                             : mcr_pkg::REM_BITS'(rem_sh);
        end
        if (cmd.root_last) begin
            step_x_reg   <= '0;
            step_y_reg   <= root_next;
            decision_reg <= mcr_pkg::DEC_ONE - DB'(root_next);
        end
        if (cmd.step_take) begin
            snap_x_reg    <= step_x_reg;
            snap_y_reg    <= step_y_reg;
            snap_done_reg <= $signed(x_c) > $signed(y_c);
            decision_reg  <= dec_next;
            step_x_reg    <= x_c[RB-1:0];
            step_y_reg    <= y_c[RB-1:0];
        end
        if (cmd.out_load) begin
            px_reg   <= px_w;
            py_reg   <= py_w;
            last_reg <= (cmd.pt_idx == mcr_pkg::LAST_POINT);
            done_reg <= snap_done_reg;
        end
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.root_last) begin
                active_reg <= 1'b1;
            end else if (cmd.step_take && ($signed(x_c) > $signed(y_c))) begin
                active_reg <= 1'b0;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_point_x      = px_reg;
    assign m_point_y      = py_reg;
    assign m_last_of_step = last_reg;
    assign m_circle_done  = done_reg;

endmodule

/* rtl/midpoint_circle_rasterizer.sv */
// Top level of the midpoint circle rasterizer: sequencer, datapath and checks.
// Start beat: busy through accept, squaring dx and dy in one shared multiplier and
//   12 root digits at one per cycle; it produces no result beat.
// Step beat: eight point beats if a circle is active, else none; the first is loaded
//   after the step snapshot, one per cycle under no stall; next taken after the eighth.
// Reset (aresetn, synchronous, active low) drops any circle and empties the output register.
module midpoint_circle_rasterizer (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_opcode,
    input  logic [mcr_pkg::COORD_BITS-1:0]        s_center_x,
    input  logic [mcr_pkg::COORD_BITS-1:0]        s_center_y,
    input  logic [mcr_pkg::COORD_BITS-1:0]        s_edge_x,
    input  logic [mcr_pkg::COORD_BITS-1:0]        s_edge_y,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [mcr_pkg::OUT_BITS-1:0]   m_point_x,
    output logic signed [mcr_pkg::OUT_BITS-1:0]   m_point_y,
    output logic                                  m_last_of_step,
    output logic                                  m_circle_done
);

    // Command bundle from the sequencer, status back from the datapath.
    mcr_pkg::mcr_cmd_t  cmd;
    mcr_pkg::mcr_stat_t stat;

    // Sequencer: decodes the input beat, walks the root digits and
    // steps through the eight octant points of a step.
    mcr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: latches the center, forms dx^2 + dy^2, takes the integer
    // square root, runs the decision update and holds the result beat.
    mcr_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_center_x     (s_center_x),
        .s_center_y     (s_center_y),
        .s_edge_x       (s_edge_x),
        .s_edge_y       (s_edge_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_point_x      (m_point_x),
        .m_point_y      (m_point_y),
        .m_last_of_step (m_last_of_step),
        .m_circle_done  (m_circle_done)
    );

`ifndef ASSERT_OFF
    // A start beat always holds off the input in the following cycle.
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_opcode == mcr_pkg::OP_START) |=> !s_ready)
        else $error("input taken while radius still in progress");

    // Points of one step flow without a gap once the sink takes them.
    a_step_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_step |=> m_valid)
        else $error("gap inside an eight point run");

    // The finish flag is common to all eight points of a step.
    a_done_const: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_step |=> m_circle_done == $past(m_circle_done))
        else $error("circle_done changed within a step");
`endif

endmodule

/* tb/tb_midpoint_circle_rasterizer.sv */
// Self-checking testbench for the midpoint circle rasterizer: directed table, then random.
module tb_midpoint_circle_rasterizer;
    import mcr_pkg::*;

    localparam int RANDOM_BEATS   = 150;   // random input beats that do work (not idle steps)
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side
    localparam int SETTLE_CYCLES  = 24;    // a step's eight points plus margin
    localparam int COORD_MAX      = (1 << COORD_BITS) - 1;

    // How a directed row is checked: by the predictor, by a result typed in here, or as producing nothing.
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_CENTER} chk_e;
    // Receiver back-pressure patterns.
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOKE} rx_mode_e;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] px;
        logic signed [OUT_BITS-1:0] py;
        logic                       last;
        logic                       done;
    } pixel_t;

    typedef struct packed {
        logic                  op;
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [COORD_BITS-1:0] ex;
        logic [COORD_BITS-1:0] ey;
        chk_e                  chk;
    } stim_row_t;

    logic                          aclk       = 1'b0;
    logic                          aresetn    = 1'b0;
    logic                          s_valid    = 1'b0;
    logic                          s_ready;
    logic                          s_opcode   = OP_START;
    logic [COORD_BITS-1:0]         s_center_x = '0;
    logic [COORD_BITS-1:0]         s_center_y = '0;
    logic [COORD_BITS-1:0]         s_edge_x   = '0;
    logic [COORD_BITS-1:0]         s_edge_y   = '0;
    logic                          m_valid;
    logic                          m_ready    = 1'b0;
    logic signed [OUT_BITS-1:0]    m_point_x;
    logic signed [OUT_BITS-1:0]    m_point_y;
    logic                          m_last_of_step;
    logic                          m_circle_done;

    midpoint_circle_rasterizer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_center_x     (s_center_x),
        .s_center_y     (s_center_y),
        .s_edge_x       (s_edge_x),
        .s_edge_y       (s_edge_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_point_x      (m_point_x),
        .m_point_y      (m_point_y),
        .m_last_of_step (m_last_of_step),
        .m_circle_done  (m_circle_done)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Circle predictor: its own copy of the rasterizer state.
    // ------------------------------------------------------------------
    logic [COORD_BITS-1:0]      circ_ox   = '0;
    logic [COORD_BITS-1:0]      circ_oy   = '0;
    int                         circ_x    = 0;
    int                         circ_y    = 0;
    logic signed [DEC_BITS-1:0] circ_dec  = '0;
    logic                       circ_live = 1'b0;

    pixel_t pending_pixels[$];   // points still owed by the block, oldest first
    int     errors        = 0;
    int     burst_left    = 0;   // beats left in the sender's current burst
    int     work_beats    = 0;   // beats that start or advance a circle

    // Directed stimulus table, walked in order after reset.
    stim_row_t dir_rows[$];

    // Append one owed point at the tail of the queue.
    function automatic void owe_pixel(input pixel_t p);
        pending_pixels.insert(pending_pixels.size(), p);
    endfunction

    task automatic add_row(input logic op,
                           input logic [COORD_BITS-1:0] cx, input logic [COORD_BITS-1:0] cy,
                           input logic [COORD_BITS-1:0] ex, input logic [COORD_BITS-1:0] ey,
                           input chk_e chk);
        stim_row_t r;
        r.op  = op;
        r.cx  = cx;
        r.cy  = cy;
        r.ex  = ex;
        r.ey  = ey;
        r.chk = chk;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    // floor(sqrt(n)), built one result bit at a time from the top
    function automatic int root_floor(input longint n);
        longint r;
        longint b;
        r = 0;
        for (b = 4096; b > 0; b = b >> 1)
            if ((r + b) * (r + b) <= n)
                r = r + b;
        return int'(r);
    endfunction

    function automatic pixel_t pixel_at(input int px, input int py,
                                        input logic last, input logic done);
        pixel_t p;
        p.px   = OUT_BITS'(px);   // wraps to the output width like the block
        p.py   = OUT_BITS'(py);
        p.last = last;
        p.done = done;
        return p;
    endfunction

    // One input beat through the predictor; pix[0..n-1] are the points it causes.
    task automatic trace_circle(input logic op,
                                input logic [COORD_BITS-1:0] cx, input logic [COORD_BITS-1:0] cy,
                                input logic [COORD_BITS-1:0] ex, input logic [COORD_BITS-1:0] ey,
                                output pixel_t pix[8], output int n);
        int   dx;
        int   dy;
        int   r;
        int   ox;
        int   oy;
        int   x;
        int   y;
        logic done;
        n = 0;
        if (op == OP_START) begin
            dx = (ex >= cx) ? int'(ex) - int'(cx) : int'(cx) - int'(ex);
            dy = (ey >= cy) ? int'(ey) - int'(cy) : int'(cy) - int'(ey);
            r  = root_floor(longint'(dx) * dx + longint'(dy) * dy);
            circ_ox   = cx;
            circ_oy   = cy;
            circ_x    = 0;
            circ_y    = r;
            circ_dec  = DEC_BITS'(1 - r);   // integer form of 1.25 - r
            circ_live = 1'b1;
        end else if (circ_live) begin
            ox = int'(circ_ox);
            oy = int'(circ_oy);
            x  = circ_x;
            y  = circ_y;
            // points come from the position before the update
            if (circ_dec < 0) begin
                circ_dec = DEC_BITS'(int'(circ_dec) + 2 * x + 3);
            end else begin
                circ_dec = DEC_BITS'(int'(circ_dec) + 2 * (x - y) + 5);
                circ_y   = y - 1;
            end
            circ_x = x + 1;
            done   = circ_x > circ_y;
            if (done)
                circ_live = 1'b0;
            pix[0] = pixel_at(ox + x, oy + y, 1'b0, done);
            pix[1] = pixel_at(ox + x, oy - y, 1'b0, done);
            pix[2] = pixel_at(ox - x, oy + y, 1'b0, done);
            pix[3] = pixel_at(ox - x, oy - y, 1'b0, done);
            pix[4] = pixel_at(ox + y, oy - x, 1'b0, done);
            pix[5] = pixel_at(ox + y, oy + x, 1'b0, done);
            pix[6] = pixel_at(ox - y, oy + x, 1'b0, done);
            pix[7] = pixel_at(ox - y, oy - x, 1'b1, done);
            n = 8;
        end
        // step while idle: nothing changes, nothing comes out
    endtask

    // ------------------------------------------------------------------
    // Sender: drives one beat, holds it until accepted, then predicts.
    // Works in bursts; between bursts valid drops for a random gap.
    // ------------------------------------------------------------------
    task automatic send_beat(input logic op,
                             input logic [COORD_BITS-1:0] cx, input logic [COORD_BITS-1:0] cy,
                             input logic [COORD_BITS-1:0] ex, input logic [COORD_BITS-1:0] ey,
                             input chk_e chk);
        pixel_t pix[8];
        int     n;
        int     gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
        end
        if (op == OP_START || circ_live)
            work_beats++;
        s_valid    <= 1'b1;
        s_opcode   <= op;
        s_center_x <= cx;
        s_center_y <= cy;
        s_edge_x   <= ex;
        s_edge_y   <= ey;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        trace_circle(op, cx, cy, ex, ey, pix, n);
        case (chk)
            CHK_MODEL: begin
                for (int k = 0; k < n; k++)
                    owe_pixel(pix[k]);
            end
            CHK_CENTER: begin
                // zero radius: the center eight times, circle finished
                for (int k = 0; k < 8; k++)
                    owe_pixel(pixel_at(int'(cx), int'(cy), k == 7, 1'b1));
            end
            default: ;   // CHK_NONE: beat must produce nothing
        endcase
    endtask

    // Stop sending and let every owed point come out.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_pixels.size() != 0);
        burst_left = 0;
    endtask

    function automatic logic [COORD_BITS-1:0] pick_center();
        case ($urandom_range(0, 5))
            0:       return COORD_BITS'($urandom_range(0, 15));
            1:       return COORD_BITS'($urandom_range(COORD_MAX - 15, COORD_MAX));
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    // Edge coordinate a small distance from c, reflected back into range.
    function automatic logic [COORD_BITS-1:0] edge_near(input logic [COORD_BITS-1:0] c);
        int off;
        int v;
        off = $urandom_range(0, 24);
        v   = $urandom_range(0, 1) ? int'(c) + off : int'(c) - off;
        if (v < 0 || v > COORD_MAX)
            v = 2 * int'(c) - v;
        return COORD_BITS'(v);
    endfunction

    // ------------------------------------------------------------------
    // Receiver: back-pressure switches at random between patterns so stalls
    // land on every point of a step.
    // ------------------------------------------------------------------
    rx_mode_e rx_mode      = RX_OPEN;
    int       rx_mode_left = 0;
    int       rx_phase     = 0;

    always @(posedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_e'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 80);
        end else begin
            rx_mode_left--;
        end
        rx_phase++;
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= (rx_phase % 4) == 0;
            RX_CHOKE:  m_ready <= (rx_phase % 13) >= 10;
        endcase
    end

    // ------------------------------------------------------------------
    // Result check: every point beat against the oldest owed point.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_points
        pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                errors++;
                $display("%0t: unexpected point beat, expected none, %s",
                         $time, "got:");
                $display("    x=%0d y=%0d last=%0b done=%0b",
                         m_point_x, m_point_y, m_last_of_step, m_circle_done);
            end else begin
                want = pending_pixels.pop_front();
                if (m_point_x !== want.px || m_point_y !== want.py ||
                    m_last_of_step !== want.last || m_circle_done !== want.done) begin
                    errors++;
                    $display("%0t: point mismatch, expected x=%0d y=%0d last=%0b done=%0b,",
                             $time, $signed(want.px), $signed(want.py), want.last, want.done);
                    $display("    got x=%0d y=%0d last=%0b done=%0b",
                             m_point_x, m_point_y, m_last_of_step, m_circle_done);
                end
            end
        end
    end

    // Watchdog: too long with no beat on either channel means a hang,
    // including points that never arrive at the end.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        stim_row_t             row;
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        int                    kind;
        int                    cap;
        int                    taken;
        int                    seq;

        // Directed: extremes, zero radius, step while idle, start while active.
        add_row(OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_NONE);   // idle after reset
        add_row(OP_START, 11'd0,    11'd0,    11'd0,    11'd0,    CHK_NONE);   // r = 0 at origin
        add_row(OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_CENTER);
        add_row(OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_NONE);   // circle finished
        add_row(OP_START, 11'd2047, 11'd2047, 11'd2047, 11'd2047, CHK_NONE);   // r = 0 far corner
        add_row(OP_STEP,  11'd2047, 11'd2047, 11'd0,    11'd0,    CHK_CENTER);
        add_row(OP_START, 11'd0,    11'd0,    11'd2047, 11'd2047, CHK_NONE);   // largest radius
        add_row(OP_STEP,  11'd2047, 11'd2047, 11'd2047, 11'd2047, CHK_MODEL);
        add_row(OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_MODEL);
        add_row(OP_START, 11'd2047, 11'd0,    11'd0,    11'd2047, CHK_NONE);   // restart mid-circle
        add_row(OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_MODEL);
        add_row(OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_MODEL);
        add_row(OP_START, 11'd5,    11'd5,    11'd6,    11'd5,    CHK_NONE);   // r = 1
        add_row(OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_MODEL);  // done on first step
        add_row(OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_NONE);
        add_row(OP_START, 11'd1024, 11'd1024, 11'd1029, 11'd1024, CHK_NONE);   // r = 5
        add_row(OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_MODEL);
        add_row(OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_MODEL);
        add_row(OP_START, 11'd100,  11'd200,  11'd100,  11'd203,  CHK_NONE);   // abandons r = 5
        add_row(OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_MODEL);
        add_row(OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_MODEL);
        add_row(OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_MODEL);  // r = 3 ends here
        add_row(OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_NONE);
        add_row(OP_START, 11'd1000, 11'd1,    11'd1000, 11'd4,    CHK_NONE);   // negative y points
        add_row(OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_MODEL);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_beat(row.op, row.cx, row.cy, row.ex, row.ey, row.chk);
        end
        hold_until_drained();

        // Random: mostly complete small circles with random centers,
        // some abandoned, some huge, some bare noise beats.
        work_beats = 0;
        seq        = 0;
        while (work_beats < RANDOM_BEATS) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                repeat ($urandom_range(1, 3))
                    send_beat(1'($urandom), 11'($urandom), 11'($urandom),
                              11'($urandom), 11'($urandom), CHK_MODEL);
            end else begin
                cx = pick_center();
                cy = pick_center();
                if (kind == 1)
                    send_beat(OP_START, cx, cy, 11'($urandom), 11'($urandom), CHK_MODEL);
                else
                    send_beat(OP_START, cx, cy, edge_near(cx), edge_near(cy), CHK_MODEL);
                // big circles and one in eight small ones get cut short
                cap   = (kind == 1 || $urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 1 << 30;
                taken = 0;
                while (circ_live && taken < cap) begin
                    send_beat(OP_STEP, 11'($urandom), 11'($urandom),
                              11'($urandom), 11'($urandom), CHK_MODEL);
                    taken++;
                end
                if ($urandom_range(0, 5) == 0)
                    send_beat(OP_STEP, 11'($urandom), 11'($urandom),
                              11'($urandom), 11'($urandom), CHK_MODEL);
            end
            seq++;
            if (seq % 7 == 3)
                hold_until_drained();
        end

        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
